// File: sv/tpq_pkg.sv
package tpq_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_SWAP_XY       = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned NUM_SLOTS = 5;

    localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd320;
    localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd480;

    // Bits of the press state byte.
    localparam logic [7:0] PRESS_BIT     = 8'h80;
    localparam logic [7:0] CAUGHT_BIT    = 8'h40;
    localparam logic [7:0] RELEASE_KEEP  = 8'hE0;
    localparam logic [7:0] PRESS_CLEAR   = 8'h7F;

    // Mode byte patterns.
    localparam logic [7:0] MODE_NO_TOUCH = 8'h80;
    localparam logic [7:0] RELEASE_MASK  = 8'h8F;

    localparam logic [15:0] COORD_NONE = 16'hFFFF;

    // Poll counter wrap.
    localparam logic [7:0] WRAP_LIMIT  = 8'd240;
    localparam int unsigned WRAP_RELOAD = 10;

    typedef struct packed {
        logic [15:0] y;
        logic [15:0] x;
    } tpq_point_t;

    typedef struct packed {
        logic [7:0]  caller_mode;
        logic [7:0]  status_byte;
        logic [31:0] raw_point0;
        logic [31:0] raw_point1;
        logic [31:0] raw_point2;
        logic [31:0] raw_point3;
        logic [31:0] raw_point4;
    } tpq_item_t;

    typedef struct packed {
        logic        touched;
        logic [7:0]  touch_state;
        logic        clear_request;
        logic        sampled;
        logic [31:0] coord0;
        logic [31:0] coord1;
        logic [31:0] coord2;
        logic [31:0] coord3;
        logic [31:0] coord4;
    } tpq_result_t;

    // Control from the scan logic to the poll divider.
    typedef struct packed {
        logic advance;
        logic restart;
    } tpq_poll_ctrl_t;

    // Split one report word into a point; swap takes X from the high half.
    function automatic tpq_point_t tpq_decode(input logic [31:0] word, input logic swap);
        tpq_point_t p;
        if (swap)
        begin
            p.x = word[31:16];
            p.y = word[15:0];
        end
        else
        begin
            p.x = word[15:0];
            p.y = word[31:16];
        end
        return p;
    endfunction

endpackage

// File: sv/tpq_if.sv
interface tpq_item_if import tpq_pkg::*; ();
    logic      valid;
    logic      ready;
    tpq_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpq_result_if import tpq_pkg::*; ();
    logic        valid;
    logic        ready;
    tpq_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/tpq_poll_divider.sv
module tpq_poll_divider import tpq_pkg::*; #(
    parameter int unsigned POLL_DIVIDE = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tpq_poll_ctrl_t ctrl,
    output logic           sampled
);

    // The remainder by POLL_DIVIDE is tracked alongside the count, so no divider is needed.
    localparam int unsigned MOD_W      = $clog2(POLL_DIVIDE + 1);
    localparam logic [MOD_W-1:0] MOD_LAST   = MOD_W'(POLL_DIVIDE - 1);
    localparam logic [MOD_W-1:0] MOD_RELOAD = MOD_W'(WRAP_RELOAD % POLL_DIVIDE);
    localparam logic [7:0] DIVIDE_8 = 8'(POLL_DIVIDE);

    logic [7:0]       count_reg, count_next, count_inc;
    logic [MOD_W-1:0] mod_reg, mod_next, mod_inc;

    // The count never exceeds the wrap limit after a call, so the increment cannot overflow.
    assign count_inc = count_reg + 8'd1;
    assign mod_inc   = (mod_reg == MOD_LAST) ? '0 : mod_reg + MOD_W'(1);
    assign sampled   = (mod_inc == '0) || (count_inc < DIVIDE_8);

    always_comb
    begin
        count_next = count_reg;
        mod_next   = mod_reg;
        if (ctrl.advance)
        begin
            if (ctrl.restart)
            begin
                count_next = '0;
                mod_next   = '0;
            end
            else if (count_inc > WRAP_LIMIT)
            begin
                count_next = 8'(WRAP_RELOAD);
                mod_next   = MOD_RELOAD;
            end
            else
            begin
                count_next = count_inc;
                mod_next   = mod_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mod_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            mod_reg   <= mod_next;
        end
    end

endmodule

// File: sv/touch_point_report_qualifier.sv
// Touch point report qualifier. Each transaction on the item channel stands for one scan call
// of a multi-touch controller: the caller's mode byte, the controller status byte and five raw
// point words. The block keeps the poll counter, the press state and five decoded points, and
// returns exactly one result transaction per item with the press state, the status clear
// request, whether the status was sampled, and all five points after the call. A new item is
// accepted in every clock cycle as long as the result register is empty or its transaction is
// being taken in the same cycle; the result is registered as its item is accepted. The whole
// call is decoded in a single pass of logic from the item port to the result register, so the
// throughput is one transaction per clock. The user must write configuration (XY swap, screen
// limits) via the plain write port only while no item is in flight; the block does not check.
module touch_point_report_qualifier import tpq_pkg::*; #(
    parameter int unsigned MAX_POINTS  = 5,
    parameter int unsigned POLL_DIVIDE = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tpq_item_if.sink               item,
    tpq_result_if.source           result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] MAX_COUNT = 4'(MAX_POINTS);

    // Configuration registers.
    logic        swap_xy_reg;
    logic [15:0] screen_width_reg;
    logic [15:0] screen_height_reg;

    // Scan state.
    logic [7:0]  press_reg, press_next;
    tpq_point_t  point_reg  [NUM_SLOTS];
    tpq_point_t  point_next [NUM_SLOTS];

    // Result register.
    logic        result_valid_reg;
    tpq_result_t result_reg, result_next;

    logic           accept;
    logic           sampled;
    tpq_poll_ctrl_t poll_ctrl;

    logic [7:0]  mode;
    logic [3:0]  count;
    logic        take;
    logic        clear;
    logic        off_screen;
    logic        restart;
    tpq_point_t  decoded [NUM_SLOTS];
    logic [31:0] raw_word [NUM_SLOTS];

    // The item side may move whenever the result register will be free at the next edge.
    assign item.ready   = !result_valid_reg || result.ready;
    assign accept       = item.valid && item.ready;
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    assign poll_ctrl.advance = accept;
    assign poll_ctrl.restart = restart;

    tpq_poll_divider #(
        .POLL_DIVIDE (POLL_DIVIDE)
    ) u_poll_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (poll_ctrl),
        .sampled (sampled)
    );

    assign raw_word[0] = item.data.raw_point0;
    assign raw_word[1] = item.data.raw_point1;
    assign raw_word[2] = item.data.raw_point2;
    assign raw_word[3] = item.data.raw_point3;
    assign raw_word[4] = item.data.raw_point4;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            decoded[i] = tpq_decode(raw_word[i], swap_xy_reg);
        end
    end

    assign count      = item.data.status_byte[3:0];
    assign take       = sampled && (count != 4'd0) && (count <= MAX_COUNT);
    assign clear      = sampled && item.data.status_byte[7] && (count <= MAX_COUNT);
    assign off_screen = (decoded[0].x > screen_width_reg) || (decoded[0].y > screen_height_reg);

    always_comb
    begin
        mode       = sampled ? item.data.status_byte : item.data.caller_mode;
        press_next = press_reg;
        restart    = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            point_next[i] = point_reg[i];
        end

        if (take)
        begin
            // A valid report: one mask bit per reported point, point 0 backed up in slot 4 if fewer than five.
            press_next    = ~(8'hFF << count) | PRESS_BIT | CAUGHT_BIT;
            point_next[4] = point_reg[0];
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (press_next[i])
                begin
                    point_next[i] = decoded[i];
                end
            end
            if (off_screen)
            begin
                if (count > 4'd1)
                begin
                    // Point 0 off the screen but another finger is down: use point 1 instead.
                    point_next[0] = decoded[1];
                    restart       = 1'b1;
                end
                else
                begin
                    // A lone point off the screen is rejected and treated as no touch.
                    point_next[0] = point_reg[0];
                    press_next    = press_reg;
                    mode          = MODE_NO_TOUCH;
                end
            end
            else
            begin
                restart = 1'b1;
            end
        end

        // Release handling: ready bit with no touch points.
        if ((mode & RELEASE_MASK) == MODE_NO_TOUCH)
        begin
            if ((press_next & PRESS_BIT) != 8'h00)
            begin
                press_next = press_next & PRESS_CLEAR;
            end
            else
            begin
                point_next[0] = '{y: COORD_NONE, x: COORD_NONE};
                press_next    = press_next & RELEASE_KEEP;
            end
        end
    end

    always_comb
    begin
        result_next.touched       = take;
        result_next.touch_state   = press_next;
        result_next.clear_request = clear;
        result_next.sampled       = sampled;
        result_next.coord0        = point_next[0];
        result_next.coord1        = point_next[1];
        result_next.coord2        = point_next[2];
        result_next.coord3        = point_next[3];
        result_next.coord4        = point_next[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_xy_reg       <= 1'b0;
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SWAP_XY:       swap_xy_reg       <= cfg_data[0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            press_reg <= press_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                point_reg[i] <= point_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: verif/tpq_report_checker.sv
module tpq_report_checker import tpq_pkg::*; #(
    parameter int unsigned MAX_POINTS  = 5,
    parameter int unsigned POLL_DIVIDE = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   call_valid,
    input  logic                   call_ready,
    input  tpq_item_t              call,
    input  logic                   report_valid,
    input  logic                   report_ready,
    input  tpq_result_t            report,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int unsigned BACKUP_SLOT = NUM_SLOTS - 1;

    // Own copy of the configuration, taken from the write port.
    logic        swap_cfg;
    logic [15:0] width_cfg;
    logic [15:0] height_cfg;

    // Own copy of the scan state.
    logic [7:0]  poll_ticks;
    logic [7:0]  press_bits;
    logic [15:0] pt_x [NUM_SLOTS];
    logic [15:0] pt_y [NUM_SLOTS];

    tpq_result_t due_reports [$];
    int          fault_tally = 0;
    int          waiting = 0;

    assign mismatches = fault_tally;
    assign pending    = waiting;

    // Works out the report of one scan call and advances the state.
    function automatic tpq_result_t qualify_call(input tpq_item_t c);
        tpq_result_t r;
        logic [31:0] raw [NUM_SLOTS];
        logic [7:0]  mode;
        logic [7:0]  saved;
        logic [7:0]  mask;
        logic [3:0]  cnt;
        logic        took_status;
        int          i;
        raw[0] = c.raw_point0;
        raw[1] = c.raw_point1;
        raw[2] = c.raw_point2;
        raw[3] = c.raw_point3;
        raw[4] = c.raw_point4;
        r = '0;
        poll_ticks = poll_ticks + 8'd1;
        took_status = (poll_ticks % POLL_DIVIDE == 0) || (poll_ticks < POLL_DIVIDE);
        mode = took_status ? c.status_byte : c.caller_mode;
        if (took_status)
        begin
            cnt = mode[3:0];
            if (mode[7] && cnt <= MAX_POINTS)
                r.clear_request = 1'b1;
            if (cnt != 0 && cnt <= MAX_POINTS)
            begin
                saved = press_bits;
                mask = 8'((1 << cnt) - 1);
                press_bits = mask | PRESS_BIT | CAUGHT_BIT;
                pt_x[BACKUP_SLOT] = pt_x[0];
                pt_y[BACKUP_SLOT] = pt_y[0];
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (press_bits[i])
                    begin
                        if (swap_cfg)
                        begin
                            pt_x[i] = raw[i][31:16];
                            pt_y[i] = raw[i][15:0];
                        end
                        else
                        begin
                            pt_x[i] = raw[i][15:0];
                            pt_y[i] = raw[i][31:16];
                        end
                    end
                end
                r.touched = 1'b1;
                if (pt_x[0] > width_cfg || pt_y[0] > height_cfg)
                begin
                    if (cnt > 1)
                    begin
                        pt_x[0] = pt_x[1];
                        pt_y[0] = pt_y[1];
                        poll_ticks = 8'd0;
                    end
                    else
                    begin
                        pt_x[0] = pt_x[BACKUP_SLOT];
                        pt_y[0] = pt_y[BACKUP_SLOT];
                        mode = MODE_NO_TOUCH;
                        press_bits = saved;
                    end
                end
                else
                begin
                    poll_ticks = 8'd0;
                end
            end
        end
        if ((mode & RELEASE_MASK) == MODE_NO_TOUCH)
        begin
            if ((press_bits & PRESS_BIT) != 0)
            begin
                press_bits = press_bits & PRESS_CLEAR;
            end
            else
            begin
                pt_x[0] = COORD_NONE;
                pt_y[0] = COORD_NONE;
                press_bits = press_bits & RELEASE_KEEP;
            end
        end
        if (poll_ticks > WRAP_LIMIT)
            poll_ticks = 8'(WRAP_RELOAD);
        r.touch_state = press_bits;
        r.sampled = took_status;
        r.coord0 = {pt_y[0], pt_x[0]};
        r.coord1 = {pt_y[1], pt_x[1]};
        r.coord2 = {pt_y[2], pt_x[2]};
        r.coord3 = {pt_y[3], pt_x[3]};
        r.coord4 = {pt_y[4], pt_x[4]};
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tpq_result_t want;
        int          i;
        if (!rst_n)
        begin
            swap_cfg   = 1'b0;
            width_cfg  = SCREEN_WIDTH_RESET;
            height_cfg = SCREEN_HEIGHT_RESET;
            poll_ticks = 8'd0;
            press_bits = 8'd0;
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                pt_x[i] = 16'd0;
                pt_y[i] = 16'd0;
            end
            due_reports.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SWAP_XY:       swap_cfg   = cfg_data[0];
                    CFG_SCREEN_WIDTH:  width_cfg  = cfg_data;
                    CFG_SCREEN_HEIGHT: height_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (call_valid && call_ready)
                due_reports.push_back(qualify_call(call));
            if (report_valid && report_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("result transaction with no call waiting for it");
                    fault_tally++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("touched", 32'(want.touched), 32'(report.touched));
                    check_field("touch_state", 32'(want.touch_state),
                                32'(report.touch_state));
                    check_field("clear_request", 32'(want.clear_request),
                                32'(report.clear_request));
                    check_field("sampled", 32'(want.sampled), 32'(report.sampled));
                    check_field("coord0", want.coord0, report.coord0);
                    check_field("coord1", want.coord1, report.coord1);
                    check_field("coord2", want.coord2, report.coord2);
                    check_field("coord3", want.coord3, report.coord3);
                    check_field("coord4", want.coord4, report.coord4);
                end
            end
        end
        waiting = due_reports.size();
    end

endmodule

// File: verif/touch_point_report_qualifier_tb.sv
// Stimulus and verdict for the touch point report qualifier. The checker beside the block
// predicts and compares every result transaction; this module only drives the clock, reset,
// the item channel, the result channel's ready and the configuration port.
module touch_point_report_qualifier_tb;
    import tpq_pkg::*;

    // The register list has three entries, so the last index of the port is unused and the
    // block must ignore writes to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT = 200000;

    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 80;

    typedef enum logic [1:0] {
        TWIST_NONE,
        TWIST_LONG_STALL,
        TWIST_DRAIN_PAUSE
    } phase_twist_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tpq_item_if   call_ch ();
    tpq_result_if report_ch ();

    int          mismatches;
    int          pending_reports;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_len = 0;
    int          cycle_count = 0;
    logic        call_taken = 1'b0;

    // Current configuration, kept here so that random points can be aimed at the screen.
    logic        cur_swap;
    logic [15:0] cur_w;
    logic [15:0] cur_h;

    touch_point_report_qualifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (call_ch),
        .result    (report_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tpq_report_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .call_valid   (call_ch.valid),
        .call_ready   (call_ch.ready),
        .call         (call_ch.data),
        .report_valid (report_ch.valid),
        .report_ready (report_ch.ready),
        .report       (report_ch.data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Whether the item on offer was taken at the last rising edge. It is sampled on the edge
    // itself and read by the sender at the following falling edge, so the sender never races
    // the block's own update of ready.
    always @(posedge clk)
        call_taken <= call_ch.valid && call_ch.ready;

    // The run is bounded by a plain cycle count; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** touch_point_report_qualifier: FAILED **");
            $finish;
        end
    end

    // The receiver. It stalls at random at the rate of the current phase; when a hold-off is
    // requested it keeps ready low for that many cycles, counting them down here, while the
    // sender goes on offering items so that the result register fills and the item channel
    // backs up.
    initial
    begin
        report_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                report_ch.ready <= 1'b0;
                hold_len--;
            end
            else
            begin
                report_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Packs a point into a report word as the block will read it under the current swap.
    function automatic logic [31:0] point_word(input logic [15:0] x, input logic [15:0] y);
        return cur_swap ? {x, y} : {y, x};
    endfunction

    // Most points land on the screen, some on or just past its edge, the rest anywhere.
    function automatic logic [31:0] random_point();
        int          pick;
        logic [15:0] x;
        logic [15:0] y;
        pick = $urandom_range(99);
        if (pick >= 80)
            return $urandom;
        if (pick < 70)
        begin
            x = 16'($urandom_range(cur_w));
            y = 16'($urandom_range(cur_h));
        end
        else
        begin
            x = cur_w + 16'($urandom_range(1));
            y = cur_h + 16'($urandom_range(1));
        end
        return point_word(x, y);
    endfunction

    // One random scan call. A normal call mostly carries a well-formed touch report of one to
    // five points; a quiet call never reports a touch, which lets the poll counter climb far
    // enough to wrap.
    function automatic tpq_item_t make_call(input bit quiet);
        tpq_item_t  c;
        int         pick;
        logic [3:0] cnt;
        logic [3:0] upper;
        logic [2:0] mode_mid;
        pick = $urandom_range(99);
        upper = 4'($urandom_range(15));
        mode_mid = 3'($urandom_range(7));
        if (quiet)
            cnt = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 6));
        else if (pick < 70)
            cnt = 4'($urandom_range(5, 1));
        else if (pick < 85)
            cnt = 4'd0;
        else
            cnt = 4'($urandom_range(15));
        c.status_byte = {upper, cnt};
        // A share of the caller's mode bytes carry the no-touch pattern, so that unsampled
        // calls drive the release logic as well.
        if ($urandom_range(99) < 30)
            c.caller_mode = {1'b1, mode_mid, 4'h0};
        else
            c.caller_mode = 8'($urandom_range(255));
        c.raw_point0 = random_point();
        c.raw_point1 = random_point();
        c.raw_point2 = random_point();
        c.raw_point3 = random_point();
        c.raw_point4 = random_point();
        return c;
    endfunction

    // Offers one scan call and returns at the falling edge after it was taken. The sender
    // idles at random first, at the rate of the current phase.
    task automatic offer_call(input tpq_item_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            call_ch.valid <= 1'b0;
            @(negedge clk);
        end
        call_ch.valid <= 1'b1;
        call_ch.data  <= c;
        @(negedge clk);
        while (!call_taken)
            @(negedge clk);
    endtask

    task automatic offer_touch(input logic [7:0] mode, input logic [7:0] status,
                               input logic [31:0] p0, input logic [31:0] p1,
                               input logic [31:0] rest);
        tpq_item_t c;
        c.caller_mode = mode;
        c.status_byte = status;
        c.raw_point0  = p0;
        c.raw_point1  = p1;
        c.raw_point2  = rest;
        c.raw_point3  = rest;
        c.raw_point4  = rest;
        offer_call(c);
    endtask

    // Stops offering and waits until every result transaction has come back. As every call
    // yields a result, the block is idle once nothing is pending.
    task automatic let_reports_drain();
        call_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_reports != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Writes all registers, then the unused index with rubbish that must be ignored. The
    // write enable is only lowered after the last write, so it is never lowered and raised
    // in the same step.
    task automatic configure(input logic [15:0] swap_word, input logic [15:0] w,
                             input logic [15:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SWAP_XY;
        cfg_data  <= swap_word;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom_range(65535));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        cur_swap = swap_word[0];
        cur_w    = w;
        cur_h    = h;
    endtask

    task automatic run_phase(input logic [15:0] swap_word, input logic [15:0] w,
                             input logic [15:0] h, input int idle_pct, input int stall_pct,
                             input int n_calls, input bit quiet, input phase_twist_t twist);
        int k;
        let_reports_drain();
        configure(swap_word, w, h);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (k = 0; k < n_calls; k++)
        begin
            if (k == n_calls / 2)
            begin
                if (twist == TWIST_LONG_STALL)
                    hold_len = HOLD_OFF_CYCLES;
                else if (twist == TWIST_DRAIN_PAUSE)
                    let_reports_drain();
            end
            offer_call(make_call(quiet));
        end
    endtask

    // Directed calls under the reset screen of 320 by 480 without swap. The comments give
    // the case each call is meant to reach.
    task automatic run_directed();
        int k;
        configure(16'h0000, SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
        // Single point at the origin, ready bit set: accepted with a clear request.
        offer_touch(8'h00, 8'h81, point_word(16'd0, 16'd0), point_word(16'd1, 16'd1), 32'h0);
        // Five points, point zero exactly on the screen corner.
        offer_touch(8'h00, 8'h85, point_word(16'd320, 16'd480), 32'hFFFF_FFFF, 32'h1234_5678);
        // Point zero just past the right edge with two points: point one takes its place.
        offer_touch(8'h00, 8'h82, point_word(16'd321, 16'd0), point_word(16'd5, 16'd6), 32'h0);
        // Point zero just below the bottom edge, single point: the old point and press state
        // come back and the call counts as no touch.
        offer_touch(8'h00, 8'h01, point_word(16'd0, 16'd481), point_word(16'd7, 16'd7), 32'h0);
        // Release twice, both with nothing pressed: the call before already cleared the press bit.
        offer_touch(8'h00, 8'h80, 32'h0, 32'h0, 32'h0);
        offer_touch(8'h00, 8'h80, 32'h0, 32'h0, 32'h0);
        // Touch counts beyond the point limit, and counts of zero, decode nothing.
        offer_touch(8'h00, 8'h86, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_touch(8'h00, 8'h8F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_touch(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_touch(8'hFF, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_touch(8'h00, 8'h70, 32'h0, 32'h0, 32'h0);
        // Point zero at the far corner of the coordinate space with three points.
        offer_touch(8'h00, 8'h83, point_word(16'hFFFF, 16'hFFFF),
                    point_word(16'd320, 16'd480), 32'hA5A5_5A5A);
        // Four points of all zeros: accepted, and the poll counter restarts.
        offer_touch(8'h00, 8'h04, 32'h0, 32'h0, 32'h0);
        // Quiet calls until the poll divider skips the status; the last two are not
        // sampled, so their status is ignored and the caller's mode byte counts instead.
        for (k = 0; k < 12; k++)
        begin
            if (k == 10)
                offer_touch(8'h80, 8'h81, 32'h0, 32'h0, 32'h0);
            else if (k == 11)
                offer_touch(8'hFF, 8'h81, 32'h0, 32'h0, 32'h0);
            else
                offer_touch(8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_SWAP_XY;
        cfg_data       = '0;
        call_ch.valid  = 1'b0;
        call_ch.data   = '0;
        cur_swap       = 1'b0;
        cur_w          = SCREEN_WIDTH_RESET;
        cur_h          = SCREEN_HEIGHT_RESET;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // Reset screen at full rate, with the long receiver hold-off halfway through.
        run_phase(16'h0000, SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, 0, 0, 150, 1'b0,
                  TWIST_LONG_STALL);
        // Largest screen with swapped axes; the sender idles and once waits for every
        // outstanding result before it carries on.
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 47, 0, 150, 1'b0, TWIST_DRAIN_PAUSE);
        // Smallest screen of 1 by 1; the receiver stalls.
        run_phase(16'hFFFE, 16'd1, 16'd1, 0, 47, 150, 1'b0, TWIST_NONE);
        // Swapped axes on a middling screen, both sides idling.
        run_phase(16'h0001, 16'd800, 16'd600, 18, 18, 150, 1'b0, TWIST_NONE);
        // No touch is ever reported, so the poll counter runs past its wrap point.
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535, 1)),
                  16'($urandom_range(65535, 1)), 18, 18, 260, 1'b1, TWIST_NONE);
        // A random screen of ordinary size to finish, with the sender idling.
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(1024, 64)),
                  16'($urandom_range(1024, 64)), 47, 0, 100, 1'b0, TWIST_NONE);

        // Everything has been offered and taken; wait for the last results and then go on watching,
        // in case the block sends something it should not.
        let_reports_drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("** touch_point_report_qualifier: PASSED **");
        else
            $display("** touch_point_report_qualifier: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/tpq_pkg.sv
sv/tpq_if.sv
sv/tpq_poll_divider.sv
sv/touch_point_report_qualifier.sv
verif/tpq_report_checker.sv
verif/touch_point_report_qualifier_tb.sv
